// ===== hw/rtl/ttmv_pkg.sv =====
// Shared types and constants of the tag table match validator.
// Depends on nothing; imported by the tag RAM, the top level, the checker and the testbench.
package ttmv_pkg;

  localparam int unsigned TagW       = 96;
  localparam int unsigned HeadW      = 32;
  localparam int unsigned TailW      = 64;
  localparam int unsigned MatchIdxW  = 10;
  localparam logic [7:0]  NoTagByte  = 8'h42;

  typedef logic [TagW-1:0] tag_t;

  typedef enum logic [1:0] {
    CMD_CLEAR    = 2'd0,
    CMD_LOAD     = 2'd1,
    CMD_FIND     = 2'd2,
    CMD_VALIDATE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_EMPTY = 2'd1,
    FAULT_FULL  = 2'd2
  } fault_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // One result item as it is held in the output register.
  typedef struct packed {
    fault_e                 fault;
    logic                   accepted;
    logic [MatchIdxW-1:0]   match_index;
    logic                   found;
  } result_t;

  // True when the head's first byte does not mark the absence of a tag.
  function automatic logic carries_tag(logic [HeadW-1:0] head);
    return head[HeadW-1 -: 8] != NoTagByte;
  endfunction

endpackage

// ===== hw/rtl/ttmv_tag_ram.sv =====
// Single-port-write, single-port-read tag memory with a registered read.
// Depends on ttmv_pkg for the tag type.
module ttmv_tag_ram
  import ttmv_pkg::*;
#(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  tag_t             wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output tag_t             rd_data_o
);

  tag_t mem [Depth];
  tag_t rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/tag_table_match_validator_unit.sv =====
// Tag table match validator: table of 96-bit tags in a block RAM with a
// sequencer for clear, load, find and validate. Depends on ttmv_pkg and ttmv_tag_ram.
//
// The block holds up to ENTRIES tags in a RAM with a registered read.
// Clear, load, find on an empty table and every validate decided without
// a search give their result in the cycle after the item is taken. A find
// on a filled table, and validate when the rule calls for a search, read
// the RAM one entry per cycle from index 0 and stop at the first match, or
// after the last stored entry is checked when none matches; the search
// result waits in a holding register until the output register is free.
// One item is in work at a time; the output register lets the next item be
// taken in the cycle its predecessor's result is taken. Loads write only
// while no search runs, so reads and writes never meet on one entry. The
// table needs no clearing pass: entries at or above the fill count are never read.
module tag_table_match_validator_unit
  import ttmv_pkg::*;
#(
  parameter int unsigned ENTRIES = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: key_head [31:0], key_tail [95:32], src_head [127:96], src_tail [191:128]
  input  logic [191:0] s_axis_tdata,
  // tuser: cmd [1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: found [0], match_index [10:1], accepted [11], fault [13:12], zero [15:14]
  output logic [15:0]  m_axis_tdata
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam logic [CntW-1:0] Full = CntW'(ENTRIES);

  // Unpack the input item
  cmd_e             cmd;
  logic [HeadW-1:0] key_head, src_head;
  logic [TailW-1:0] key_tail, src_tail;
  tag_t             key_tag, src_tag;

  assign cmd      = cmd_e'(s_axis_tuser);
  assign key_head = s_axis_tdata[31:0];
  assign key_tail = s_axis_tdata[95:32];
  assign src_head = s_axis_tdata[127:96];
  assign src_tail = s_axis_tdata[191:128];
  assign key_tag  = {key_head, key_tail};
  assign src_tag  = {src_head, src_tail};

  // State
  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] rd_q, rd_d;
  logic            chk_q, chk_d;
  logic [CntW-1:0] chk_idx_q, chk_idx_d;
  tag_t            key_q, key_d;
  logic            is_validate_q, is_validate_d;
  result_t         pend_q, pend_d;
  result_t         out_q, out_d;
  logic            out_valid_q, out_valid_d;

  // RAM ports
  logic            wr_en, rd_en;
  tag_t            rd_data;

  logic            in_fire, out_free, hit, last_chk;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign hit           = chk_q && (rd_data == key_q);
  assign last_chk      = chk_q && ((chk_idx_q + CntW'(1)) == count_q);

  assign wr_en = in_fire && (cmd == CMD_LOAD) && (count_q != Full);
  assign rd_en = (state_q == ST_SCAN) && (rd_q < count_q);

  ttmv_tag_ram #(
    .Depth (ENTRIES),
    .AddrW (IdxW)
  ) u_tag_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[IdxW-1:0]),
    .wr_data_i (key_tag),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_q[IdxW-1:0]),
    .rd_data_o (rd_data)
  );

  // Next state, datapath and result selection
  always_comb begin
    result_t res;
    state_d       = state_q;
    count_d       = count_q;
    rd_d          = rd_q;
    chk_d         = 1'b0;
    chk_idx_d     = rd_q;
    key_d         = key_q;
    is_validate_d = is_validate_q;
    pend_d        = pend_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    res           = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          key_d         = key_tag;
          is_validate_d = (cmd == CMD_VALIDATE);
          rd_d          = '0;
          unique case (cmd)
            CMD_CLEAR: begin
              count_d     = '0;
              out_d       = res;
              out_valid_d = 1'b1;
            end
            CMD_LOAD: begin
              if (count_q == Full) begin
                res.fault = FAULT_FULL;
              end else begin
                count_d = count_q + CntW'(1);
              end
              out_d       = res;
              out_valid_d = 1'b1;
            end
            CMD_FIND: begin
              if (count_q == '0) begin
                res.fault   = FAULT_EMPTY;
                out_d       = res;
                out_valid_d = 1'b1;
              end else begin
                state_d = ST_SCAN;
              end
            end
            CMD_VALIDATE: begin
              priority if (!carries_tag(key_head) || (key_tag == src_tag)) begin
                res.accepted = 1'b1;
                out_d        = res;
                out_valid_d  = 1'b1;
              end else if (carries_tag(src_head)) begin
                out_d       = res;
                out_valid_d = 1'b1;
              end else if (count_q == '0) begin
                res.fault   = FAULT_EMPTY;
                out_d       = res;
                out_valid_d = 1'b1;
              end else begin
                state_d = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        // Stop at the first hit or after the last stored entry is checked
        if (hit || last_chk) begin
          pend_d             = '0;
          pend_d.found       = hit;
          pend_d.match_index = hit ? MatchIdxW'(chk_idx_q) : '0;
          pend_d.accepted    = is_validate_q && !hit;
          state_d            = ST_FINISH;
        end else begin
          chk_d = rd_en;
          if (rd_en) begin
            rd_d = rd_q + CntW'(1);
          end
        end
      end

      ST_FINISH: begin
        // Hold the search result until the output register is free
        if (out_free) begin
          out_d       = pend_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rd_q        <= '0;
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_q        <= rd_d;
      chk_q       <= chk_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    chk_idx_q     <= chk_idx_d;
    key_q         <= key_d;
    is_validate_q <= is_validate_d;
    pend_q        <= pend_d;
    out_q         <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q};

`ifndef SYNTH
  // A RAM check is only pending while a search runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_q |-> (state_q == ST_SCAN))
    else $error("entry check pending outside a search");

  // Fill count never exceeds the table depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full)
    else $error("entry count above table depth");

  // Reads never run past the stored entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (rd_q <= count_q))
    else $error("search read beyond fill count");

  // A checked entry always lies below the fill count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_q |-> (chk_idx_q < count_q))
    else $error("checked entry not stored");
`endif

endmodule

// ===== test/tag_table_match_checker.sv =====
// Checker of the tag table match validator: watches both streams, predicts
// each result from a shadow tag table and compares field by field.
// Depends on ttmv_pkg for the command, fault and result types.
module tag_table_match_checker
  import ttmv_pkg::*;
#(
  parameter int unsigned ENTRIES = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [15:0]  m_axis_tdata,
  output int unsigned  fail_count,
  output int unsigned  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxReports = 40;

  // Shadow of the tag table; tags held as {head, tail}
  tag_t        shadow_tags [ENTRIES];
  int unsigned fill_level = 0;
  result_t     expected_results [$];
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned outstanding = 0;
  result_t     got_res;
  result_t     want_res;

  assign fail_count = mismatches;
  assign pending    = outstanding;

  task automatic report_mismatch(string what, logic [31:0] got_v, logic [31:0] want_v);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("%0t ns: result %0d: %s is %0d, expected %0d",
               $time, results_seen, what, got_v, want_v);
    end
  endtask

  // Lowest index among the filled entries that holds the tag, or -1
  function automatic int lowest_match(tag_t tag);
    for (int i = 0; i < int'(fill_level); i++) begin
      if (shadow_tags[i] == tag) return i;
    end
    return -1;
  endfunction

  // Apply one item to the shadow table and work out its result
  function automatic result_t predict_item(cmd_e cmd, tag_t key, tag_t src);
    result_t res;
    int      hit;
    res = '0;
    hit = -1;
    case (cmd)
      CMD_CLEAR: begin
        fill_level = 0;
      end
      CMD_LOAD: begin
        if (fill_level >= ENTRIES) begin
          res.fault = FAULT_FULL;
        end else begin
          shadow_tags[fill_level] = key;
          fill_level++;
        end
      end
      CMD_FIND: begin
        if (fill_level == 0) res.fault = FAULT_EMPTY;
        else hit = lowest_match(key);
      end
      default: begin
        // validate: no change tag or equal pair accepts, tagged source rejects
        if (key[TagW-1 -: 8] == NoTagByte || key == src) begin
          res.accepted = 1'b1;
        end else if (src[TagW-1 -: 8] != NoTagByte) begin
          res.accepted = 1'b0;
        end else if (fill_level == 0) begin
          res.fault = FAULT_EMPTY;
        end else begin
          hit = lowest_match(key);
          res.accepted = (hit < 0);
        end
      end
    endcase
    if (hit >= 0) begin
      res.found       = 1'b1;
      res.match_index = hit[MatchIdxW-1:0];
    end
    return res;
  endfunction

  // Compare each taken result first, then predict the item taken at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_results.delete();
      fill_level  = 0;
      outstanding = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_res = result_t'(m_axis_tdata[13:0]);
        if (expected_results.size() == 0) begin
          report_mismatch("result with no item waiting, data", 32'(m_axis_tdata), 0);
        end else begin
          want_res = expected_results.pop_front();
          if (got_res.found !== want_res.found)
            report_mismatch("found", 32'(got_res.found), 32'(want_res.found));
          if (got_res.match_index !== want_res.match_index)
            report_mismatch("match_index", 32'(got_res.match_index),
                            32'(want_res.match_index));
          if (got_res.accepted !== want_res.accepted)
            report_mismatch("accepted", 32'(got_res.accepted), 32'(want_res.accepted));
          if (got_res.fault !== want_res.fault)
            report_mismatch("fault", 32'(got_res.fault), 32'(want_res.fault));
          if (m_axis_tdata[15:14] !== 2'b00)
            report_mismatch("pad bits", 32'(m_axis_tdata[15:14]), 0);
        end
        results_seen++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(predict_item(
          cmd_e'(s_axis_tuser),
          {s_axis_tdata[31:0], s_axis_tdata[95:32]},
          {s_axis_tdata[127:96], s_axis_tdata[191:128]}));
      end
      outstanding = expected_results.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
// Testbench top of the tag table match validator: clock, reset, item stimulus,
// random output stalls, watchdog and verdict.
// Depends on ttmv_pkg, tag_table_match_validator_unit and tag_table_match_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ttmv_pkg::*;

  localparam int unsigned Entries       = 1024;
  localparam int unsigned WatchdogLimit = 4 * (Entries + 16);
  localparam int unsigned MixedItems    = 520;
  localparam int unsigned TailLoads     = 32;
  localparam int unsigned DrainCycles   = 16;

  typedef enum int unsigned {
    Q_FIND_HIT,
    Q_FIND_MISS,
    Q_NEAR_MISS,
    Q_VAL_NO_CHANGE,
    Q_VAL_EQUAL,
    Q_VAL_TAGGED_SRC,
    Q_VAL_HIT,
    Q_VAL_MISS
  } query_e;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [15:0]  m_axis_tdata;

  int unsigned fail_count;
  int unsigned pending;
  bit          calm;
  int unsigned items_sent;
  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;
  tag_t        stored_tags [$];

  tag_table_match_validator_unit #(
    .ENTRIES(Entries)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  tag_table_match_checker #(
    .ENTRIES(Entries)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic tag_t rand_tag();
    return {$urandom(), $urandom(), $urandom()};
  endfunction

  // Force a real tag: first byte differs from the no-tag marker
  function automatic tag_t with_tag(tag_t t);
    if (t[TagW-1 -: 8] == NoTagByte) t[TagW-8] = ~t[TagW-8];
    return t;
  endfunction

  function automatic tag_t without_tag(tag_t t);
    t[TagW-1 -: 8] = NoTagByte;
    return t;
  endfunction

  function automatic tag_t pick_stored();
    if (stored_tags.size() == 0) return rand_tag();
    return stored_tags[$urandom_range(0, stored_tags.size() - 1)];
  endfunction

  // Drive one item from a falling edge, hold it until taken
  task automatic send_item(cmd_e cmd, tag_t key, tag_t src);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {src[TailW-1:0], src[TagW-1 -: HeadW],
                      key[TailW-1:0], key[TagW-1 -: HeadW]};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    // track the table so that queries can aim at stored tags
    case (cmd)
      CMD_CLEAR: stored_tags.delete();
      CMD_LOAD:  if (stored_tags.size() < Entries) stored_tags.push_back(key);
      default:   ;
    endcase
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic run_directed();
    tag_t twin;
    twin = with_tag(rand_tag());
    // queries on an empty table
    send_item(CMD_FIND, '1, '0);
    send_item(CMD_VALIDATE, '1, without_tag('0));
    send_item(CMD_VALIDATE, without_tag('0), '1);
    // extremes, a duplicate and an untagged entry
    send_item(CMD_LOAD, '0, '1);
    send_item(CMD_LOAD, '1, '0);
    send_item(CMD_LOAD, twin, '0);
    send_item(CMD_LOAD, twin, '1);
    send_item(CMD_LOAD, without_tag('1), '0);
    send_item(CMD_FIND, '1, '0);
    send_item(CMD_FIND, twin, '0);
    send_item(CMD_FIND, '0, '1);
    send_item(CMD_FIND, without_tag('1), '0);
    send_item(CMD_FIND, twin ^ tag_t'(1), '0);
    // each branch of the acceptance rule
    send_item(CMD_VALIDATE, twin, twin);
    send_item(CMD_VALIDATE, '1, '1);
    send_item(CMD_VALIDATE, twin, '1);
    send_item(CMD_VALIDATE, twin, without_tag(rand_tag()));
    send_item(CMD_VALIDATE, with_tag(rand_tag()), without_tag('0));
    send_item(CMD_VALIDATE, without_tag('1), without_tag('1));
    // back to empty
    send_item(CMD_CLEAR, '1, '1);
    send_item(CMD_FIND, '0, '0);
    send_item(CMD_VALIDATE, '0, without_tag('0));
  endtask

  task automatic run_query();
    query_e kind;
    tag_t   key;
    tag_t   src;
    cmd_e   cmd;
    kind = query_e'($urandom_range(Q_FIND_HIT, Q_VAL_MISS));
    cmd  = CMD_VALIDATE;
    src  = without_tag(rand_tag());
    case (kind)
      Q_FIND_HIT: begin
        cmd = CMD_FIND;
        key = pick_stored();
      end
      Q_FIND_MISS: begin
        cmd = CMD_FIND;
        key = rand_tag();
      end
      Q_NEAR_MISS: begin
        cmd = ($urandom_range(0, 1) != 0) ? CMD_FIND : CMD_VALIDATE;
        key = with_tag(pick_stored() ^ (tag_t'(1) << $urandom_range(0, TagW - 1)));
      end
      Q_VAL_NO_CHANGE: begin
        key = without_tag(pick_stored());
        src = ($urandom_range(0, 1) != 0) ? key : rand_tag();
      end
      Q_VAL_EQUAL: begin
        key = with_tag(pick_stored());
        src = key;
      end
      Q_VAL_TAGGED_SRC: begin
        key = with_tag(pick_stored());
        src = with_tag(rand_tag());
      end
      Q_VAL_HIT: key = with_tag(pick_stored());
      default:   key = with_tag(rand_tag());
    endcase
    send_item(cmd, key, src);
  endtask

  // Well-formed run: optional clear, a batch of loads, then queries
  task automatic run_sequence();
    int unsigned n;
    if ($urandom_range(0, 2) != 0) send_item(CMD_CLEAR, rand_tag(), rand_tag());
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 12);
    repeat (n) begin
      if (stored_tags.size() != 0 && $urandom_range(0, 5) == 0)
        send_item(CMD_LOAD, pick_stored(), rand_tag());
      else
        send_item(CMD_LOAD, rand_tag(), rand_tag());
    end
    repeat ($urandom_range(3, 10)) run_query();
  endtask

  task automatic run_noise();
    repeat ($urandom_range(1, 4))
      send_item(cmd_e'($urandom_range(CMD_CLEAR, CMD_VALIDATE)), rand_tag(), rand_tag());
  endtask

  // Load a short table back to back and search both of its ends
  task automatic run_tail();
    tag_t key;
    send_item(CMD_CLEAR, '0, '0);
    for (int unsigned i = 0; i < TailLoads; i++) begin
      key = with_tag(rand_tag());
      key[MatchIdxW-1:0] = i[MatchIdxW-1:0];
      send_item(CMD_LOAD, key, rand_tag());
    end
    send_item(CMD_FIND, stored_tags[TailLoads-1], '0);
    send_item(CMD_FIND, stored_tags[0], '0);
    send_item(CMD_FIND, stored_tags[$urandom_range(1, TailLoads - 2)], '0);
    send_item(CMD_FIND, with_tag(rand_tag()), '0);
    send_item(CMD_VALIDATE, stored_tags[TailLoads-1], without_tag(rand_tag()));
    send_item(CMD_VALIDATE, with_tag(rand_tag()), without_tag(rand_tag()));
    send_item(CMD_CLEAR, '1, '1);
    send_item(CMD_FIND, '1, '1);
  endtask

  // Stall the output in short random bursts
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Stop the run when neither stream moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_CLEAR;
    calm          = 1'b0;
    items_sent    = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    while (items_sent < MixedItems) begin
      if ($urandom_range(0, 6) == 0) run_noise();
      else run_sequence();
    end
    calm = 1'b1;
    run_tail();
    s_axis_tvalid <= 1'b0;

    // drain the outstanding results
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== tag_table_match_validator_unit.f =====
hw/rtl/ttmv_pkg.sv
hw/rtl/ttmv_tag_ram.sv
hw/rtl/tag_table_match_validator_unit.sv
test/tag_table_match_checker.sv
test/tb_top.sv
